>>> sv/rhou_pkg.sv
package rhou_pkg;

  localparam int MAX_RECTS_DEF  = 8;
  localparam int COORD_BITS_DEF = 12;
  localparam int SLOT_BITS      = 3;
  localparam int COLOR_BITS     = 8;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_PIXEL = 2'd2
  } cmd_t;

  // Control that travels alongside each transaction through the cell chain.
  typedef struct packed {
    logic                 vld;
    cmd_t                 cmd;
    logic [SLOT_BITS-1:0] slot;
    logic                 covered;
  } ctrl_t;

  // x / 10 for x below 2048, as a multiplication by a scaled reciprocal.
  function automatic logic [COLOR_BITS-1:0] div10(input logic [10:0] x);
    logic [23:0] prod;
    prod = 24'(x) * 24'd6554;
    return prod[23:16];
  endfunction

  // (c*8)/10 + (col*2)/10; the sum never exceeds 255.
  function automatic logic [COLOR_BITS-1:0] blend(input logic [COLOR_BITS-1:0] c,
                                                  input logic [COLOR_BITS-1:0] col);
    logic [COLOR_BITS:0] sum;
    sum = {1'b0, div10({c, 3'b000})} + {1'b0, div10({2'b00, col, 1'b0})};
    return sum[COLOR_BITS-1:0];
  endfunction

endpackage

>>> sv/rhou_cell.sv
module rhou_cell
  import rhou_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  ctrl_t                 ctrl_in,
  input  logic [COORD_BITS-1:0] x_in,
  input  logic [COORD_BITS-1:0] y_in,
  input  logic [COORD_BITS-1:0] w_in,
  input  logic [COORD_BITS-1:0] h_in,
  input  logic [COLOR_BITS-1:0] r_in,
  input  logic [COLOR_BITS-1:0] g_in,
  input  logic [COLOR_BITS-1:0] b_in,
  output ctrl_t                 ctrl_out,
  output logic [COORD_BITS-1:0] x_out,
  output logic [COORD_BITS-1:0] y_out,
  output logic [COORD_BITS-1:0] w_out,
  output logic [COORD_BITS-1:0] h_out,
  output logic [COLOR_BITS-1:0] r_out,
  output logic [COLOR_BITS-1:0] g_out,
  output logic [COLOR_BITS-1:0] b_out
);

  // Rectangle held by this cell. Right and bottom carry one extra bit so that
  // a rectangle running past the coordinate range is clipped, not wrapped.
  logic                  active;
  logic [COORD_BITS-1:0] left;
  logic [COORD_BITS-1:0] top;
  logic [COORD_BITS:0]   right;
  logic [COORD_BITS:0]   bottom;
  logic [COLOR_BITS-1:0] col_r;
  logic [COLOR_BITS-1:0] col_g;
  logic [COLOR_BITS-1:0] col_b;

  logic                  selected;
  logic [COORD_BITS:0]   x_ext;
  logic [COORD_BITS:0]   y_ext;
  logic [COORD_BITS:0]   right_next;
  logic [COORD_BITS:0]   bottom_next;
  logic                  hit;
  logic                  border;
  ctrl_t                 ctrl_next;
  logic [COLOR_BITS-1:0] r_next;
  logic [COLOR_BITS-1:0] g_next;
  logic [COLOR_BITS-1:0] b_next;

  assign selected = ctrl_in.vld && (int'(ctrl_in.slot) == INDEX);
  assign x_ext    = {1'b0, x_in};
  assign y_ext    = {1'b0, y_in};

  assign right_next  = x_ext + {1'b0, w_in} - 1'b1;
  assign bottom_next = (h_in == '0) ? y_ext : (y_ext + {1'b0, h_in} - 1'b1);

  assign hit = active && (x_in >= left) && (x_ext <= right)
               && (y_in >= top) && (y_ext <= bottom);
  assign border = (x_in == left) || (x_ext == right) || (y_in == top) || (y_ext == bottom);

  always_comb begin
    ctrl_next = ctrl_in;
    r_next    = r_in;
    g_next    = g_in;
    b_next    = b_in;
    if (ctrl_in.vld && ctrl_in.cmd == CMD_PIXEL && hit) begin
      if (border) begin
        r_next = col_r;
        g_next = col_g;
        b_next = col_b;
      end else if (!ctrl_in.covered) begin
        r_next = blend(r_in, col_r);
        g_next = blend(g_in, col_g);
        b_next = blend(b_in, col_b);
      end
      ctrl_next.covered = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (advance && selected) begin
      unique case (ctrl_in.cmd)
        CMD_LOAD: begin
          active <= (w_in != '0);
        end
        CMD_CLEAR: begin
          active <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance && selected && ctrl_in.cmd == CMD_LOAD) begin
      left   <= x_in;
      top    <= y_in;
      right  <= right_next;
      bottom <= bottom_next;
      col_r  <= r_in;
      col_g  <= g_in;
      col_b  <= b_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.vld <= 1'b0;
    end else if (advance) begin
      ctrl_out.vld <= ctrl_next.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctrl_out.cmd     <= ctrl_next.cmd;
      ctrl_out.slot    <= ctrl_next.slot;
      ctrl_out.covered <= ctrl_next.covered;
      x_out            <= x_in;
      y_out            <= y_in;
      w_out            <= w_in;
      h_out            <= h_in;
      r_out            <= r_next;
      g_out            <= g_next;
      b_out            <= b_next;
    end
  end

endmodule

>>> sv/rectangle_highlight_overlay_unit.sv
// Rectangle highlight overlay. Every input transaction (load a slot, clear a
// slot, or process a pixel) enters a chain of MAX_RECTS identical cells, one
// per rectangle slot, lowest slot first, and moves one cell per clock cycle
// unless the chain is stalled. A new transaction can be taken in every cycle
// in which stall is low, so the sustained rate is one pixel per clock while
// no result is held. There is one register per cell; the last cell's
// register drives the result ports. Loads and clears travel down the same
// chain and update their slot's cell only when they reach it, so every pixel
// sees exactly the slots written before it and none written after it. Only
// pixel transactions produce a result; loads, clears and the unused command
// code give none, and loads and clears naming a slot beyond the table change
// no cell. The whole chain holds still while a result waits under
// result_stall, and stall is raised towards the source for exactly those
// cycles. Slots are empty after reset; no clearing pass is needed.
module rectangle_highlight_overlay_unit
  import rhou_pkg::*;
#(
  parameter int MAX_RECTS  = MAX_RECTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid,
  output logic                  stall,
  input  logic [1:0]            command,
  input  logic [SLOT_BITS-1:0]  slot,
  input  logic [COORD_BITS-1:0] pos_x,
  input  logic [COORD_BITS-1:0] pos_y,
  input  logic [COORD_BITS-1:0] size_w,
  input  logic [COORD_BITS-1:0] size_h,
  input  logic [COLOR_BITS-1:0] red,
  input  logic [COLOR_BITS-1:0] green,
  input  logic [COLOR_BITS-1:0] blue,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [COLOR_BITS-1:0] out_red,
  output logic [COLOR_BITS-1:0] out_green,
  output logic [COLOR_BITS-1:0] out_blue,
  output logic                  covered
);

  // Stage 0 is the incoming transaction; stage i+1 is the register of cell i.
  ctrl_t                 ctrl_chain [0:MAX_RECTS];
  logic [COORD_BITS-1:0] x_chain    [0:MAX_RECTS];
  logic [COORD_BITS-1:0] y_chain    [0:MAX_RECTS];
  logic [COORD_BITS-1:0] w_chain    [0:MAX_RECTS];
  logic [COORD_BITS-1:0] h_chain    [0:MAX_RECTS];
  logic [COLOR_BITS-1:0] r_chain    [0:MAX_RECTS];
  logic [COLOR_BITS-1:0] g_chain    [0:MAX_RECTS];
  logic [COLOR_BITS-1:0] b_chain    [0:MAX_RECTS];

  logic advance;

  // The last cell's register doubles as the output register. It is only a
  // result when it carries a pixel; anything else simply drops out.
  assign result_valid = ctrl_chain[MAX_RECTS].vld && (ctrl_chain[MAX_RECTS].cmd == CMD_PIXEL);
  assign advance      = !(result_valid && result_stall);
  assign stall        = !advance;

  assign ctrl_chain[0].vld     = valid;
  assign ctrl_chain[0].cmd     = cmd_t'(command);
  assign ctrl_chain[0].slot    = slot;
  assign ctrl_chain[0].covered = 1'b0;
  assign x_chain[0]            = pos_x;
  assign y_chain[0]            = pos_y;
  assign w_chain[0]            = size_w;
  assign h_chain[0]            = size_h;
  assign r_chain[0]            = red;
  assign g_chain[0]            = green;
  assign b_chain[0]            = blue;

  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
    rhou_cell #(
      .INDEX      (i),
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .ctrl_in  (ctrl_chain[i]),
      .x_in     (x_chain[i]),
      .y_in     (y_chain[i]),
      .w_in     (w_chain[i]),
      .h_in     (h_chain[i]),
      .r_in     (r_chain[i]),
      .g_in     (g_chain[i]),
      .b_in     (b_chain[i]),
      .ctrl_out (ctrl_chain[i+1]),
      .x_out    (x_chain[i+1]),
      .y_out    (y_chain[i+1]),
      .w_out    (w_chain[i+1]),
      .h_out    (h_chain[i+1]),
      .r_out    (r_chain[i+1]),
      .g_out    (g_chain[i+1]),
      .b_out    (b_chain[i+1])
    );
  end

  assign out_red   = r_chain[MAX_RECTS];
  assign out_green = g_chain[MAX_RECTS];
  assign out_blue  = b_chain[MAX_RECTS];
  assign covered   = ctrl_chain[MAX_RECTS].covered;

  // Back-pressure reaches the source only while a result is being held.
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    stall |-> (result_valid && result_stall))
    else $error("stall raised without a held result");

  // Reset empties the chain, so no result can follow it directly.
  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result present straight after reset");

  // While the chain is frozen, the first cell keeps the transaction it holds.
  a_chain_frozen: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(ctrl_chain[1].vld) && $stable(ctrl_chain[1].cmd))
    else $error("first cell changed while the chain was halted");

endmodule

>>> verif/rectangle_highlight_overlay_unit_test.sv
module rectangle_highlight_overlay_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rhou_pkg::*;

  localparam int PERIOD     = 4;
  localparam int NSLOTS     = MAX_RECTS_DEF;
  localparam int CBITS      = COORD_BITS_DEF;
  localparam int COORD_MAX  = (1 << CBITS) - 1;
  localparam int LIMIT      = 200000;
  // The chain is one cell per slot long; the drain allows a good margin on top.
  localparam int DRAIN      = 4 * NSLOTS;
  // Random rectangles are mostly packed into one small window so that they overlap.
  localparam int WIN_X      = 100;
  localparam int WIN_Y      = 200;
  // Command code that the block decodes as nothing at all.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One transaction towards the block, every payload field at its port width.
  typedef struct {
    logic [1:0]            cmd;
    logic [SLOT_BITS-1:0]  slot;
    logic [CBITS-1:0]      x;
    logic [CBITS-1:0]      y;
    logic [CBITS-1:0]      w;
    logic [CBITS-1:0]      h;
    logic [COLOR_BITS-1:0] r;
    logic [COLOR_BITS-1:0] g;
    logic [COLOR_BITS-1:0] b;
  } overlay_xact_t;

  // One processed pixel as the block should return it.
  typedef struct {
    logic [COLOR_BITS-1:0] r;
    logic [COLOR_BITS-1:0] g;
    logic [COLOR_BITS-1:0] b;
    logic                  cov;
  } pixel_t;

  // All inputs start at known values.
  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  valid        = 1'b0;
  logic [1:0]            command      = CMD_PIXEL;
  logic [SLOT_BITS-1:0]  slot         = '0;
  logic [CBITS-1:0]      pos_x        = '0;
  logic [CBITS-1:0]      pos_y        = '0;
  logic [CBITS-1:0]      size_w       = '0;
  logic [CBITS-1:0]      size_h       = '0;
  logic [COLOR_BITS-1:0] red          = '0;
  logic [COLOR_BITS-1:0] green        = '0;
  logic [COLOR_BITS-1:0] blue         = '0;
  logic                  result_stall = 1'b0;
  logic                  stall;
  logic                  result_valid;
  logic [COLOR_BITS-1:0] out_red;
  logic [COLOR_BITS-1:0] out_green;
  logic [COLOR_BITS-1:0] out_blue;
  logic                  covered;

  // The testbench's own copy of the rectangle table, updated as each
  // transaction is accepted. Acceptance order is the order in which the
  // block's cell chain applies loads and clears, so this copy is exact.
  logic                  tbl_live [NSLOTS];
  logic [CBITS-1:0]      tbl_left [NSLOTS];
  logic [CBITS-1:0]      tbl_top  [NSLOTS];
  logic [CBITS-1:0]      tbl_wid  [NSLOTS];
  logic [CBITS-1:0]      tbl_hgt  [NSLOTS];
  logic [COLOR_BITS-1:0] tbl_r    [NSLOTS];
  logic [COLOR_BITS-1:0] tbl_g    [NSLOTS];
  logic [COLOR_BITS-1:0] tbl_b    [NSLOTS];

  // Pixels accepted but not yet returned, oldest first.
  pixel_t pending_pixels[$];

  int errors     = 0;
  int cycles     = 0;
  int n_loads    = 0;
  int n_clears   = 0;
  int n_ignored  = 0;
  int n_pixels   = 0;
  int n_results  = 0;
  int n_covered  = 0;

  // Sender burst state; gaps_on switches source idling off for whole stretches.
  int burst_left = 0;
  bit gaps_on    = 1'b1;

  // Receiver stall pattern state.
  int stall_run  = 0;
  int free_run   = 0;

  rectangle_highlight_overlay_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .valid        (valid),
    .stall        (stall),
    .command      (command),
    .slot         (slot),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .size_w       (size_w),
    .size_h       (size_h),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .covered      (covered)
  );

  always #(PERIOD / 2.0) clk = ~clk;

  // Interior tint: four fifths of the pixel plus one fifth of the rectangle,
  // each part truncated on its own.
  function automatic logic [COLOR_BITS-1:0] tint_component(input logic [COLOR_BITS-1:0] c,
                                                           input logic [COLOR_BITS-1:0] col);
    int sum;
    sum = (int'(c) * 8) / 10 + (int'(col) * 2) / 10;
    return COLOR_BITS'(sum);
  endfunction

  // Runs one pixel through the table, lowest slot first. Borders paint the
  // rectangle's colour outright; an interior is tinted only by the first
  // rectangle to cover the pixel. Extents are computed wide, so a rectangle
  // that runs off the coordinate range is clipped rather than wrapped.
  function automatic pixel_t overlay_pixel(input overlay_xact_t t);
    pixel_t p;
    int     x1, y1, x2, y2, px, py;
    bit     edge_hit;
    p.r   = t.r;
    p.g   = t.g;
    p.b   = t.b;
    p.cov = 1'b0;
    px    = int'(t.x);
    py    = int'(t.y);
    for (int i = 0; i < NSLOTS; i++) begin
      if (!tbl_live[i] || tbl_wid[i] == 0) continue;
      x1 = int'(tbl_left[i]);
      y1 = int'(tbl_top[i]);
      x2 = x1 + int'(tbl_wid[i]) - 1;
      y2 = y1 + ((tbl_hgt[i] > 0) ? int'(tbl_hgt[i]) - 1 : 0);
      if (px < x1 || px > x2 || py < y1 || py > y2) continue;
      edge_hit = (px == x1) || (px == x2) || (py == y1) || (py == y2);
      if (edge_hit) begin
        p.r = tbl_r[i];
        p.g = tbl_g[i];
        p.b = tbl_b[i];
      end else if (!p.cov) begin
        p.r = tint_component(p.r, tbl_r[i]);
        p.g = tint_component(p.g, tbl_g[i]);
        p.b = tint_component(p.b, tbl_b[i]);
      end
      p.cov = 1'b1;
    end
    return p;
  endfunction

  // Applies an accepted transaction to the table copy, or queues the pixel
  // it should produce.
  function automatic void track_xact(input overlay_xact_t t);
    case (t.cmd)
      CMD_LOAD: begin
        tbl_live[t.slot] = 1'b1;
        tbl_left[t.slot] = t.x;
        tbl_top[t.slot]  = t.y;
        tbl_wid[t.slot]  = t.w;
        tbl_hgt[t.slot]  = t.h;
        tbl_r[t.slot]    = t.r;
        tbl_g[t.slot]    = t.g;
        tbl_b[t.slot]    = t.b;
        n_loads++;
      end
      CMD_CLEAR: begin
        tbl_live[t.slot] = 1'b0;
        n_clears++;
      end
      CMD_PIXEL: begin
        pending_pixels.push_back(overlay_pixel(t));
        n_pixels++;
      end
      default: n_ignored++;
    endcase
  endfunction

  // Every field random, so that fields a command does not use still toggle.
  function automatic overlay_xact_t random_xact();
    overlay_xact_t t;
    t.cmd  = 2'($urandom_range(0, 3));
    t.slot = SLOT_BITS'($urandom);
    t.x    = CBITS'($urandom);
    t.y    = CBITS'($urandom);
    t.w    = CBITS'($urandom);
    t.h    = CBITS'($urandom);
    t.r    = COLOR_BITS'($urandom);
    t.g    = COLOR_BITS'($urandom);
    t.b    = COLOR_BITS'($urandom);
    return t;
  endfunction

  function automatic overlay_xact_t load_xact(input int s, input int x, input int y,
                                              input int w, input int h,
                                              input int r, input int g, input int b);
    overlay_xact_t t;
    t      = random_xact();
    t.cmd  = CMD_LOAD;
    t.slot = SLOT_BITS'(s);
    t.x    = CBITS'(x);
    t.y    = CBITS'(y);
    t.w    = CBITS'(w);
    t.h    = CBITS'(h);
    t.r    = COLOR_BITS'(r);
    t.g    = COLOR_BITS'(g);
    t.b    = COLOR_BITS'(b);
    return t;
  endfunction

  function automatic overlay_xact_t pixel_xact(input int x, input int y,
                                               input int r, input int g, input int b);
    overlay_xact_t t;
    t     = random_xact();
    t.cmd = CMD_PIXEL;
    t.x   = CBITS'(x);
    t.y   = CBITS'(y);
    t.r   = COLOR_BITS'(r);
    t.g   = COLOR_BITS'(g);
    t.b   = COLOR_BITS'(b);
    return t;
  endfunction

  function automatic overlay_xact_t command_xact(input logic [1:0] c, input int s);
    overlay_xact_t t;
    t      = random_xact();
    t.cmd  = c;
    t.slot = SLOT_BITS'(s);
    return t;
  endfunction

  // Picks a coordinate on, inside, or just outside one side of a rectangle.
  function automatic logic [CBITS-1:0] aim_coord(input int lo, input int len);
    int hi;
    hi = lo + ((len > 0) ? len - 1 : 0);
    if (hi > COORD_MAX) hi = COORD_MAX;
    case ($urandom_range(0, 5))
      0:       return CBITS'(lo);
      1:       return CBITS'(hi);
      2:       return CBITS'(lo - 1);
      3:       return CBITS'(hi + 1);
      default: return CBITS'($urandom_range(lo, hi));
    endcase
  endfunction

  // Sends one transaction. The source works in bursts: when a burst runs out
  // valid drops for a random gap, unless gaps are switched off. Inputs change
  // only on the falling edge, and the payload is held until accepted.
  task automatic send_xact(input overlay_xact_t t);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    command = t.cmd;
    slot    = t.slot;
    pos_x   = t.x;
    pos_y   = t.y;
    size_w  = t.w;
    size_h  = t.h;
    red     = t.r;
    green   = t.g;
    blue    = t.b;
    valid   = 1'b1;
    do @(posedge clk); while (stall);
    track_xact(t);
  endtask

  // With an empty table every pixel passes through untouched, at both
  // corners of the coordinate range and both ends of the colour range.
  task automatic test_empty_table();
    send_xact(pixel_xact(0, 0, 0, 0, 0));
    send_xact(pixel_xact(COORD_MAX, COORD_MAX, 255, 255, 255));
  endtask

  // A single rectangle: each of its four sides, a corner, the interior and a
  // pixel just beyond the right-hand edge.
  task automatic test_border_and_interior();
    send_xact(load_xact(0, 10, 20, 5, 4, 255, 0, 128));
    send_xact(pixel_xact(10, 20, 1, 2, 3));
    send_xact(pixel_xact(14, 22, 1, 2, 3));
    send_xact(pixel_xact(12, 23, 1, 2, 3));
    send_xact(pixel_xact(12, 21, 255, 255, 255));
    send_xact(pixel_xact(15, 21, 9, 9, 9));
  endtask

  // Overlapping slots: a later border overrides, while a later interior
  // leaves a pixel that an earlier slot already tinted.
  task automatic test_stacking();
    send_xact(load_xact(1, 11, 21, 3, 2, 0, 255, 255));
    send_xact(load_xact(2, 8, 18, 10, 10, 255, 255, 255));
    send_xact(pixel_xact(12, 21, 200, 100, 50));
    send_xact(pixel_xact(9, 19, 0, 128, 255));
    send_xact(pixel_xact(16, 25, 255, 0, 0));
  endtask

  // Degenerate shapes and commands: zero width is skipped, zero height counts
  // as one row, rectangles past the top of the range are clipped, the unused
  // command code is dropped, and a cleared slot stops drawing.
  task automatic test_degenerate();
    send_xact(load_xact(3, 0, 0, 0, 7, 255, 255, 255));
    send_xact(pixel_xact(0, 0, 17, 34, 51));
    send_xact(load_xact(4, COORD_MAX, COORD_MAX, 1, 0, 0, 0, 0));
    send_xact(load_xact(5, 4090, 4090, COORD_MAX, COORD_MAX, 255, 0, 255));
    send_xact(pixel_xact(COORD_MAX, COORD_MAX, 255, 255, 255));
    send_xact(pixel_xact(4093, 4093, 255, 255, 255));
    send_xact(command_xact(CMD_UNUSED, 0));
    send_xact(command_xact(CMD_CLEAR, 0));
    send_xact(pixel_xact(12, 21, 100, 100, 100));
  endtask

  // Random traffic. Loads mostly place small rectangles in one window so that
  // they overlap; a few are fully random or pushed against the top of the
  // range. Most pixels are aimed at the edges of a loaded slot.
  task automatic test_random_traffic(input int n_items);
    overlay_xact_t t;
    int            counted;
    int            roll;
    int            s;
    counted = 0;
    while (counted < n_items) begin
      if (counted % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      t    = random_xact();
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        t.cmd = CMD_LOAD;
        case ($urandom_range(0, 9))
          0: ;
          1: begin
            t.x = CBITS'(COORD_MAX - $urandom_range(0, 40));
            t.y = CBITS'(COORD_MAX - $urandom_range(0, 40));
            if ($urandom_range(0, 1)) t.w = CBITS'($urandom_range(1, 60));
            if ($urandom_range(0, 1)) t.h = CBITS'($urandom_range(0, 60));
          end
          default: begin
            t.x = CBITS'(WIN_X + $urandom_range(0, 48));
            t.y = CBITS'(WIN_Y + $urandom_range(0, 48));
            t.w = CBITS'($urandom_range(0, 20));
            t.h = CBITS'($urandom_range(0, 20));
          end
        endcase
      end else if (roll < 16) begin
        t.cmd = CMD_CLEAR;
      end else if (roll < 19) begin
        t.cmd = CMD_UNUSED;
      end else begin
        t.cmd = CMD_PIXEL;
        s     = $urandom_range(0, NSLOTS - 1);
        if ($urandom_range(0, 9) < 7 && tbl_live[s] && tbl_wid[s] != 0) begin
          t.x = aim_coord(int'(tbl_left[s]), int'(tbl_wid[s]));
          t.y = aim_coord(int'(tbl_top[s]), int'(tbl_hgt[s]));
        end else if ($urandom_range(0, 1)) begin
          t.x = CBITS'(WIN_X + $urandom_range(0, 70));
          t.y = CBITS'(WIN_Y + $urandom_range(0, 70));
        end
      end
      send_xact(t);
      if (t.cmd != CMD_UNUSED) counted++;
    end
  endtask

  // The receiver stalls in runs of random length, with free stretches of
  // random length between them; now and then a long free stretch.
  always @(negedge clk) begin
    if (stall_run > 0) begin
      stall_run    <= stall_run - 1;
      result_stall <= 1'b1;
    end else if (free_run > 0) begin
      free_run     <= free_run - 1;
      result_stall <= 1'b0;
    end else begin
      stall_run    <= $urandom_range(0, 4);
      free_run     <= ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 8);
      result_stall <= 1'b0;
    end
  end

  // Each accepted result is compared with the oldest pending pixel.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && result_valid && !result_stall) begin
      n_results++;
      if (pending_pixels.size() == 0) begin
        $error("result with no pixel pending: %0d %0d %0d covered %0b",
               out_red, out_green, out_blue, covered);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (want.cov) n_covered++;
        if (out_red !== want.r) begin
          $error("out_red expected %0d actual %0d", want.r, out_red);
          errors++;
        end
        if (out_green !== want.g) begin
          $error("out_green expected %0d actual %0d", want.g, out_green);
          errors++;
        end
        if (out_blue !== want.b) begin
          $error("out_blue expected %0d actual %0d", want.b, out_blue);
          errors++;
        end
        if (covered !== want.cov) begin
          $error("covered expected %0b actual %0b", want.cov, covered);
          errors++;
        end
      end
    end
  end

  // Watchdog: the slowest correct run is a small fraction of this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timed out after %0d cycles with %0d pixels outstanding",
               cycles, pending_pixels.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NSLOTS; i++) tbl_live[i] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_border_and_interior();
    test_stacking();
    test_degenerate();
    test_random_traffic(550);

    @(negedge clk);
    valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    // Anything the block still emits now would be a spurious result.
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d loads, %0d clears, %0d unused codes and %0d pixels.",
             n_loads, n_clears, n_ignored, n_pixels);
    $display("Checked %0d results, %0d of them under a rectangle, %0d mismatches.",
             n_results, n_covered, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> rectangle_highlight_overlay_unit.f
sv/rhou_pkg.sv
sv/rhou_cell.sv
sv/rectangle_highlight_overlay_unit.sv
verif/rectangle_highlight_overlay_unit_test.sv
